>>> rtl/core/prq_pkg.sv
// types and constants shared by the priority ready queue modules
package prq_pkg;

	localparam int SLOT_W = 6;
	localparam int PRIO_W = 3;
	localparam int CNT_W  = 7;

	// widest slot index space that the slot field can address
	localparam int SLOT_SPACE = 64;

	// least urgent priority, larger numbers are saturated to it
	localparam logic [PRIO_W:0] LEAST_URGENT = 4'd6;

	localparam logic MODE_INSERT = 1'b0;
	localparam logic MODE_REMOVE = 1'b1;

	typedef enum logic [1:0] {
		ERR_OK     = 2'd0,
		ERR_DUP    = 2'd1,
		ERR_ABSENT = 2'd2
	} error_code_t;

	typedef struct packed {
		logic              mode;
		logic [SLOT_W-1:0] task_slot;
		logic [PRIO_W-1:0] task_priority;
	} req_t;

	typedef struct packed {
		logic [SLOT_W-1:0] head_slot;
		logic              head_valid;
		logic [1:0]        error_code;
		logic [CNT_W-1:0]  queued_count;
	} rsp_t;

	// one queue entry as held in the order memory
	typedef struct packed {
		logic [SLOT_W-1:0] slot;
		logic [PRIO_W-1:0] prio;
	} entry_t;

	// commands from the controller to the datapath
	typedef struct packed {
		logic load;
		logic ins_rd;
		logic ins_step;
		logic ins_put;
		logic rem_rd;
		logic rem_step;
		logic rem_end;
		logic emit;
	} dp_cmd_t;

	// status from the datapath to the controller
	typedef struct packed {
		error_code_t chk_err;
		logic        mode;
		logic        len_zero;
		logic        shift_ok;
		logic        ptr_one;
		logic        rem_last;
		logic        out_free;
	} dp_stat_t;

endpackage

>>> rtl/core/prq_stream_if.sv
// valid/ready channel carrying one payload per transaction
interface prq_stream_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (
		output valid,
		output payload,
		input  ready
	);

	modport sink (
		input  valid,
		input  payload,
		output ready
	);
endinterface

>>> rtl/core/priority_ready_queue.sv
// Priority ready queue: keeps task slots in priority order (lower number more urgent,
// first come first within one priority) and answers each insert or remove transaction
// with the head slot, a non-empty flag, the queue length and an error code. One
// transaction is worked on at a time. The order is held in a memory with a registered
// read, so every entry visited costs a read state and a compare state: an insert visits
// the s entries that it moves towards the tail and one more unless it goes to the front
// of the queue, a remove on a queue of n entries visits all n, and a rejected
// transaction (duplicate slot, full queue, absent or out of range slot) visits none. The
// result sits in an output register, so the next transaction is taken while a finished
// result still waits to be read.
module priority_ready_queue #(
	parameter int SLOT_COUNT = 64
) (
	input  logic         clk,
	input  logic         arst_n,
	prq_stream_if.sink   req,
	prq_stream_if.source rsp
);
	import prq_pkg::*;

	localparam int DEPTH = (SLOT_COUNT < SLOT_SPACE) ? SLOT_COUNT : SLOT_SPACE;

	dp_cmd_t  cmd;
	dp_stat_t stat;

	// control sequencer
	prq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.cmd       (cmd),
		.stat      (stat)
	);

	// queue storage and result register
	prq_datapath #(
		.SLOT_COUNT (SLOT_COUNT)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_data  (req.payload),
		.cmd       (cmd),
		.stat      (stat),
		.rsp_data  (rsp.payload),
		.rsp_valid (rsp.valid),
		.rsp_ready (rsp.ready)
	);

	// one transaction in flight at a time
	a_single_item: assert property (@(posedge clk) disable iff (!arst_n)
		req.valid && req.ready |=> !req.ready)
		else $error("request taken while a transaction is in progress");

	// a result never overwrites one that is still waiting
	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> stat.out_free)
		else $error("result register loaded while occupied");

	// head flag agrees with the reported length
	a_head_len: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid |-> (rsp.payload.head_valid == (rsp.payload.queued_count != '0)))
		else $error("head flag inconsistent with queue length");

	// length stays within the storage depth
	a_len_bound: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid |-> (rsp.payload.queued_count <= CNT_W'(DEPTH)))
		else $error("queue length beyond storage depth");

endmodule

>>> rtl/core/prq_datapath.sv
// order memory, presence bits, scan pointer and result register of the ready queue
module prq_datapath #(
	parameter int SLOT_COUNT = 64
) (
	input  logic            clk,
	input  logic            arst_n,
	input  prq_pkg::req_t   req_data,
	input  prq_pkg::dp_cmd_t cmd,
	output prq_pkg::dp_stat_t stat,
	output prq_pkg::rsp_t   rsp_data,
	output logic            rsp_valid,
	input  logic            rsp_ready
);
	import prq_pkg::*;

	localparam int DEPTH = (SLOT_COUNT < SLOT_SPACE) ? SLOT_COUNT : SLOT_SPACE;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	entry_t              mem [DEPTH];
	entry_t              rdata_q;
	logic [DEPTH-1:0]    present_q;
	logic [SLOT_W-1:0]   slot_q;
	logic [PRIO_W-1:0]   prio_q;
	error_code_t         err_q;
	logic [CNT_W-1:0]    ptr_q;
	logic [CNT_W-1:0]    len_q;
	logic                found_q;
	logic [SLOT_W-1:0]   head_q;
	rsp_t                rsp_q;
	logic                rsp_valid_q;

	logic [CNT_W-1:0]    ptr_dec;
	logic                in_range;
	logic [AW-1:0]       req_idx;
	logic [PRIO_W-1:0]   prio_sat;
	error_code_t         chk_err;
	logic                rd_en;
	logic [AW-1:0]       rd_addr;
	logic                wr_en;
	logic [AW-1:0]       wr_addr;
	entry_t              wr_data;

	assign ptr_dec  = ptr_q - CNT_W'(1);
	assign in_range = {3'b000, req_data.task_slot} < 9'(SLOT_COUNT);
	assign req_idx  = req_data.task_slot[AW-1:0];

	// saturate the priority to the least urgent level
	assign prio_sat = ({1'b0, req_data.task_priority} > LEAST_URGENT) ?
		LEAST_URGENT[PRIO_W-1:0] : req_data.task_priority;

	// error check of the incoming transaction against the present state
	always_comb begin
		chk_err = ERR_OK;
		if (!in_range) begin
			chk_err = ERR_ABSENT;
		end else if (req_data.mode == MODE_INSERT) begin
			if (present_q[req_idx] || (len_q >= CNT_W'(DEPTH)))
				chk_err = ERR_DUP;
		end else if (!present_q[req_idx]) begin
			chk_err = ERR_ABSENT;
		end
	end

	// memory port selection
	always_comb begin
		rd_en   = cmd.ins_rd || cmd.rem_rd;
		rd_addr = cmd.ins_rd ? ptr_dec[AW-1:0] : ptr_q[AW-1:0];
		wr_en   = 1'b0;
		wr_addr = ptr_q[AW-1:0];
		wr_data = rdata_q;
		if (cmd.ins_step) begin
			wr_en = 1'b1;
		end else if (cmd.ins_put) begin
			wr_en   = 1'b1;
			wr_data = '{slot: slot_q, prio: prio_q};
		end else if (cmd.rem_step && found_q) begin
			wr_en   = 1'b1;
			wr_addr = ptr_dec[AW-1:0];
		end
	end

	// order memory, one write and one registered read a cycle
	always_ff @(posedge clk) begin
		if (wr_en)
			mem[wr_addr] <= wr_data;
		if (rd_en)
			rdata_q <= mem[rd_addr];
	end

	// copy of the front entry's slot
	always_ff @(posedge clk) begin
		if (wr_en && (wr_addr == '0))
			head_q <= wr_data.slot;
	end

	// captured transaction fields
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			slot_q <= req_data.task_slot;
			prio_q <= prio_sat;
			err_q  <= chk_err;
		end
	end

	// scan pointer, length, presence bits and match flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q     <= '0;
			len_q     <= '0;
			present_q <= '0;
			found_q   <= 1'b0;
		end else begin
			if (cmd.load) begin
				ptr_q   <= (req_data.mode == MODE_REMOVE) ? '0 : len_q;
				found_q <= 1'b0;
			end
			if (cmd.ins_step)
				ptr_q <= ptr_dec;
			if (cmd.rem_step) begin
				ptr_q   <= ptr_q + CNT_W'(1);
				found_q <= found_q || (rdata_q.slot == slot_q);
			end
			if (cmd.ins_put) begin
				len_q                   <= len_q + CNT_W'(1);
				present_q[slot_q[AW-1:0]] <= 1'b1;
			end
			if (cmd.rem_end) begin
				len_q                   <= len_q - CNT_W'(1);
				present_q[slot_q[AW-1:0]] <= 1'b0;
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			rsp_q.head_slot    <= (len_q != '0) ? head_q : '0;
			rsp_q.head_valid   <= (len_q != '0);
			rsp_q.error_code   <= err_q;
			rsp_q.queued_count <= len_q;
		end
	end

	assign rsp_data  = rsp_q;
	assign rsp_valid = rsp_valid_q;

	// status towards the controller
	assign stat.chk_err  = chk_err;
	assign stat.mode     = req_data.mode;
	assign stat.len_zero = (len_q == '0);
	assign stat.shift_ok = (rdata_q.prio > prio_q);
	assign stat.ptr_one  = (ptr_q == CNT_W'(1));
	assign stat.rem_last = ((ptr_q + CNT_W'(1)) == len_q);
	assign stat.out_free = !rsp_valid_q || rsp_ready;

endmodule

>>> rtl/core/prq_ctrl.sv
// sequencer that steps the datapath through an insert or remove scan
module prq_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_ready,
	output prq_pkg::dp_cmd_t  cmd,
	input  prq_pkg::dp_stat_t stat
);
	import prq_pkg::*;

	typedef enum logic [7:0] {
		ST_IDLE    = 8'b0000_0001,
		ST_INS_RD  = 8'b0000_0010,
		ST_INS_CMP = 8'b0000_0100,
		ST_INS_PUT = 8'b0000_1000,
		ST_REM_RD  = 8'b0001_0000,
		ST_REM_CMP = 8'b0010_0000,
		ST_REM_END = 8'b0100_0000,
		ST_FIN     = 8'b1000_0000
	} state_t;

	state_t state_q;
	state_t state_d;

	assign req_ready = (state_q == ST_IDLE);

	// next state and datapath commands
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (req_valid) begin
					cmd.load = 1'b1;
					if (stat.chk_err != ERR_OK)
						state_d = ST_FIN;
					else if (stat.mode == MODE_REMOVE)
						state_d = ST_REM_RD;
					else if (stat.len_zero)
						state_d = ST_INS_PUT;
					else
						state_d = ST_INS_RD;
				end
			end
			ST_INS_RD: begin
				cmd.ins_rd = 1'b1;
				state_d    = ST_INS_CMP;
			end
			ST_INS_CMP: begin
				if (stat.shift_ok) begin
					cmd.ins_step = 1'b1;
					state_d      = stat.ptr_one ? ST_INS_PUT : ST_INS_RD;
				end else begin
					state_d = ST_INS_PUT;
				end
			end
			ST_INS_PUT: begin
				cmd.ins_put = 1'b1;
				state_d     = ST_FIN;
			end
			ST_REM_RD: begin
				cmd.rem_rd = 1'b1;
				state_d    = ST_REM_CMP;
			end
			ST_REM_CMP: begin
				cmd.rem_step = 1'b1;
				state_d      = stat.rem_last ? ST_REM_END : ST_REM_RD;
			end
			ST_REM_END: begin
				cmd.rem_end = 1'b1;
				state_d     = ST_FIN;
			end
			ST_FIN: begin
				if (stat.out_free) begin
					cmd.emit = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

endmodule
